@@ rtl/aarm_pkg.sv @@
`default_nettype none

package aarm_pkg;

  // CORDIC depth, capped at the arctangent table length
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  // square root: one root bit per stage, division: one quotient bit per stage
  localparam int SQ_STEPS  = 30;
  localparam int DIV_STEPS = 30;

  localparam logic signed [31:0] ONE_Q29     = 32'sd536870912;
  localparam logic signed [31:0] HALF_PI_Q29 = 32'sd843314857;
  localparam logic signed [31:0] PI_Q29      = 32'sd1686629713;
  localparam logic signed [31:0] GAIN_Q29    = 32'sd326016437;
  localparam logic signed [15:0] ENTRY_MAX   = 16'sd16384;

  localparam logic signed [31:0] ATAN_Q29 [ATAN_ENTRIES] = '{
    32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
    32'sd33510843,  32'sd16771758,  32'sd8387925,   32'sd4194219,
    32'sd2097141,   32'sd1048575,   32'sd524288,    32'sd262144,
    32'sd131072,    32'sd65536,     32'sd32768,     32'sd16384,
    32'sd8192,      32'sd4096,      32'sd2048,      32'sd1024,
    32'sd512,       32'sd256,       32'sd128,       32'sd64
  };

  // data that rides alongside the normalize / sqrt / divide stages
  typedef struct packed {
    logic                    zero;
    logic [2:0]              neg;
    logic [2:0][15:0]        mag;
    logic signed [31:0]      cx;
    logic signed [31:0]      cy;
    logic signed [31:0]      cz;
    logic                    flip;
  } side_t;

  // rounded Q.28 product: (a*b + 2^27) >>> 28
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd134217728;
    return p[59:28];
  endfunction

  // Q.29 sum to Q1.14 with rounding and saturation
  function automatic logic signed [15:0] to_q14(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic sub);
    logic signed [32:0] v;
    logic signed [17:0] e;
    v = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
    v = v + 33'sd16384;
    e = v[32:15];
    if (e > 18'sd16384) begin
      return ENTRY_MAX;
    end else if (e < -18'sd16384) begin
      return -ENTRY_MAX;
    end
    return e[15:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/axis_angle_rotation_matrix_core.sv @@
`default_nettype none

// Channel  | handshake               | beat
// ---------+-------------------------+-----------------------------------------
// input    | in_valid / in_ready     | axis_x, axis_y, axis_z, angle
// output   | out_valid / out_ready   | r00..r22, axis_was_zero
//
// One beat enters per cycle unless the output stalls; stages: 4 prep, 30 square
// root, 30 divider, 3 multiply, then the output register.
// The square root and the three unit-vector divisions each resolve one bit
// per stage; CORDIC runs alongside the first square root stages.
// rst (synchronous) clears every valid bit; payload registers are not reset.
// The whole pipe advances together whenever the output register is empty or
// being drained, so a stall freezes every stage in place.

module axis_angle_rotation_matrix_core import aarm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [15:0] angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] r00,
  output logic signed [15:0] r01,
  output logic signed [15:0] r02,
  output logic signed [15:0] r10,
  output logic signed [15:0] r11,
  output logic signed [15:0] r12,
  output logic signed [15:0] r20,
  output logic signed [15:0] r21,
  output logic signed [15:0] r22,
  output logic               axis_was_zero
);

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------------------------------------------------------- P1
  // magnitudes, squares, angle range reduction
  logic [15:0]        ma_x, ma_y, ma_z;
  logic signed [31:0] z_in, z_red;
  logic               flip_in;

  always_comb begin
    ma_x = axis_x[15] ? 16'(-axis_x) : axis_x;
    ma_y = axis_y[15] ? 16'(-axis_y) : axis_y;
    ma_z = axis_z[15] ? 16'(-axis_z) : axis_z;
    z_in = {angle, 16'h0000};
    if (z_in > HALF_PI_Q29) begin
      z_red   = z_in - PI_Q29;
      flip_in = 1'b1;
    end else if (z_in < -HALF_PI_Q29) begin
      z_red   = z_in + PI_Q29;
      flip_in = 1'b1;
    end else begin
      z_red   = z_in;
      flip_in = 1'b0;
    end
  end

  logic        p1_vld;
  logic [31:0] p1_sq [3];
  side_t       p1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else if (adv) begin
      p1_vld <= in_valid;
    end
    if (adv) begin
      p1_sq[0]      <= 32'(ma_x) * 32'(ma_x);
      p1_sq[1]      <= 32'(ma_y) * 32'(ma_y);
      p1_sq[2]      <= 32'(ma_z) * 32'(ma_z);
      p1_side.zero  <= (axis_x == 16'sd0) && (axis_y == 16'sd0) && (axis_z == 16'sd0);
      p1_side.neg   <= {axis_z[15], axis_y[15], axis_x[15]};
      p1_side.mag   <= {ma_z, ma_y, ma_x};
      p1_side.cx    <= GAIN_Q29;
      p1_side.cy    <= 32'sd0;
      p1_side.cz    <= z_red;
      p1_side.flip  <= flip_in;
    end
  end

  // ---------------------------------------------------------------- P2
  logic        p2_vld;
  logic [31:0] p2_n2;
  side_t       p2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else if (adv) begin
      p2_vld <= p1_vld;
    end
    if (adv) begin
      p2_n2   <= p1_sq[0] + p1_sq[1] + p1_sq[2];
      p2_side <= p1_side;
    end
  end

  // ---------------------------------------------------------------- P3
  // scale by 4^k so the squared norm lands in [2^30, 2^32)
  logic [3:0] k_c;
  logic       k_done;

  always_comb begin
    k_c    = 4'd0;
    k_done = 1'b0;
    for (int j = 0; j < 15; j++) begin
      if (!k_done && (p2_n2[31-2*j -: 2] == 2'b00)) begin
        k_c = 4'(j + 1);
      end else begin
        k_done = 1'b1;
      end
    end
  end

  logic        p3_vld;
  logic [31:0] p3_n2n;
  logic [3:0]  p3_k;
  side_t       p3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_vld <= 1'b0;
    end else if (adv) begin
      p3_vld <= p2_vld;
    end
    if (adv) begin
      p3_n2n  <= p2_n2 << {k_c, 1'b0};
      p3_k    <= k_c;
      p3_side <= p2_side;
    end
  end

  // ---------------------------------------------------------------- P4
  // scaled axis magnitudes (always below 2^16 after scaling)
  side_t p3_side_sh;

  always_comb begin
    p3_side_sh = p3_side;
    for (int l = 0; l < 3; l++) begin
      p3_side_sh.mag[l] = 16'(32'(p3_side.mag[l]) << p3_k);
    end
  end

  logic        p4_vld;
  logic [31:0] p4_src;
  side_t       p4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_vld <= 1'b0;
    end else if (adv) begin
      p4_vld <= p3_vld;
    end
    if (adv) begin
      p4_src  <= p3_n2n;
      p4_side <= p3_side_sh;
    end
  end

  // ---------------------------------------------------------------- sqrt
  // r = floor(sqrt(n2n * 2^28)); two radicand bits per stage, CORDIC in the
  // first CSTEPS stages
  logic        sq_vld  [1:SQ_STEPS];
  logic [29:0] sq_root [1:SQ_STEPS];
  logic [31:0] sq_rem  [1:SQ_STEPS];
  logic [31:0] sq_src  [1:SQ_STEPS];
  side_t       sq_side [1:SQ_STEPS];

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
    logic        i_vld;
    logic [29:0] i_root;
    logic [31:0] i_rem;
    logic [31:0] i_src;
    side_t       i_side;
    logic [33:0] rem_s, trial;
    logic        ge;
    side_t       side_n;

    if (g == 0) begin : g_first
      assign i_vld  = p4_vld;
      assign i_root = 30'd0;
      assign i_rem  = 32'd0;
      assign i_src  = p4_src;
      assign i_side = p4_side;
    end else begin : g_rest
      assign i_vld  = sq_vld[g];
      assign i_root = sq_root[g];
      assign i_rem  = sq_rem[g];
      assign i_src  = sq_src[g];
      assign i_side = sq_side[g];
    end

    always_comb begin
      rem_s  = {i_rem, i_src[31:30]};
      trial  = {2'b00, i_root, 2'b01};
      ge     = rem_s >= trial;
      side_n = i_side;
      if (g < CSTEPS) begin
        if (!i_side.cz[31]) begin
          side_n.cx = i_side.cx - (i_side.cy >>> g);
          side_n.cy = i_side.cy + (i_side.cx >>> g);
          side_n.cz = i_side.cz - ATAN_Q29[g % ATAN_ENTRIES];
        end else begin
          side_n.cx = i_side.cx + (i_side.cy >>> g);
          side_n.cy = i_side.cy - (i_side.cx >>> g);
          side_n.cz = i_side.cz + ATAN_Q29[g % ATAN_ENTRIES];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[g+1] <= 1'b0;
      end else if (adv) begin
        sq_vld[g+1] <= i_vld;
      end
      if (adv) begin
        sq_rem[g+1]  <= ge ? 32'(rem_s - trial) : rem_s[31:0];
        sq_root[g+1] <= {i_root[28:0], ge};
        sq_src[g+1]  <= i_src << 2;
        sq_side[g+1] <= side_n;
      end
    end
  end

  // ---------------------------------------------------------------- divide
  // u = round(mag * 2^42 / r): remainder starts at mag << 12, the low
  // dividend bits are r >> 1 (the rounding term)
  logic                  dv_vld  [1:DIV_STEPS];
  logic [29:0]           dv_r    [1:DIV_STEPS];
  logic [2:0][29:0]      dv_rem  [1:DIV_STEPS];
  logic [2:0][29:0]      dv_q    [1:DIV_STEPS];
  side_t                 dv_side [1:DIV_STEPS];

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_dv
    logic             i_vld;
    logic [29:0]      i_r;
    logic [2:0][29:0] i_rem;
    logic [2:0][29:0] i_q;
    side_t            i_side;
    logic [29:0]      r_half;
    logic [2:0][30:0] rem_s;
    logic [2:0]       ge;
    logic [2:0][29:0] rem_n;
    logic [2:0][29:0] q_n;

    if (g == 0) begin : g_first
      assign i_vld  = sq_vld[SQ_STEPS];
      assign i_r    = sq_root[SQ_STEPS];
      assign i_q    = '0;
      assign i_side = sq_side[SQ_STEPS];
      for (genvar l = 0; l < 3; l++) begin : g_init
        assign i_rem[l] = {2'b00, sq_side[SQ_STEPS].mag[l], 12'h000};
      end
    end else begin : g_rest
      assign i_vld  = dv_vld[g];
      assign i_r    = dv_r[g];
      assign i_rem  = dv_rem[g];
      assign i_q    = dv_q[g];
      assign i_side = dv_side[g];
    end

    always_comb begin
      r_half = i_r >> 1;
      for (int l = 0; l < 3; l++) begin
        rem_s[l] = {i_rem[l], r_half[DIV_STEPS-1-g]};
        ge[l]    = rem_s[l] >= {1'b0, i_r};
        rem_n[l] = ge[l] ? 30'(rem_s[l] - {1'b0, i_r}) : rem_s[l][29:0];
        q_n[l]   = {i_q[l][28:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[g+1] <= 1'b0;
      end else if (adv) begin
        dv_vld[g+1] <= i_vld;
      end
      if (adv) begin
        dv_r[g+1]    <= i_r;
        dv_rem[g+1]  <= rem_n;
        dv_q[g+1]    <= q_n;
        dv_side[g+1] <= i_side;
      end
    end
  end

  // ---------------------------------------------------------------- M0
  // signed unit vector, cos, sin, 1 - cos
  side_t              dl;
  logic signed [31:0] c_c;
  assign dl  = dv_side[DIV_STEPS];
  assign c_c = dl.flip ? -dl.cx : dl.cx;

  logic               m0_vld, m0_zero;
  logic signed [31:0] m0_u [3];
  logic signed [31:0] m0_c, m0_s, m0_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      m0_vld <= 1'b0;
    end else if (adv) begin
      m0_vld <= dv_vld[DIV_STEPS];
    end
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        m0_u[l] <= dl.neg[l] ? -$signed({2'b00, dv_q[DIV_STEPS][l]})
                             :  $signed({2'b00, dv_q[DIV_STEPS][l]});
      end
      m0_c    <= c_c;
      m0_s    <= dl.flip ? -dl.cy : dl.cy;
      m0_t    <= ONE_Q29 - c_c;
      m0_zero <= dl.zero;
    end
  end

  // ---------------------------------------------------------------- M1
  logic               m1_vld, m1_zero;
  logic signed [31:0] m1_u [3];
  logic signed [31:0] m1_tu [3];
  logic signed [31:0] m1_su [3];
  logic signed [31:0] m1_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else if (adv) begin
      m1_vld <= m0_vld;
    end
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        m1_tu[l] <= mulq(m0_t, m0_u[l]);
        m1_su[l] <= mulq(m0_s, m0_u[l]);
      end
      m1_u    <= m0_u;
      m1_c    <= m0_c;
      m1_zero <= m0_zero;
    end
  end

  // ---------------------------------------------------------------- M2
  logic               m2_vld, m2_zero;
  logic signed [31:0] m2_xx, m2_xy, m2_xz, m2_yy, m2_yz, m2_zz;
  logic signed [31:0] m2_su [3];
  logic signed [31:0] m2_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_vld <= 1'b0;
    end else if (adv) begin
      m2_vld <= m1_vld;
    end
    if (adv) begin
      m2_xx   <= mulq(m1_tu[0], m1_u[0]);
      m2_xy   <= mulq(m1_tu[0], m1_u[1]);
      m2_xz   <= mulq(m1_tu[0], m1_u[2]);
      m2_yy   <= mulq(m1_tu[1], m1_u[1]);
      m2_yz   <= mulq(m1_tu[1], m1_u[2]);
      m2_zz   <= mulq(m1_tu[2], m1_u[2]);
      m2_su   <= m1_su;
      m2_c    <= m1_c;
      m2_zero <= m1_zero;
    end
  end

  // ---------------------------------------------------------------- output
  // Rodrigues sums, rounding to Q1.14; zero axis forces the identity
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= m2_vld;
    end
    if (adv) begin
      axis_was_zero <= m2_zero;
      if (m2_zero) begin
        r00 <= ENTRY_MAX; r01 <= 16'sd0;     r02 <= 16'sd0;
        r10 <= 16'sd0;    r11 <= ENTRY_MAX; r12 <= 16'sd0;
        r20 <= 16'sd0;    r21 <= 16'sd0;     r22 <= ENTRY_MAX;
      end else begin
        r00 <= to_q14(m2_xx, m2_c,     1'b0);
        r01 <= to_q14(m2_xy, m2_su[2], 1'b1);
        r02 <= to_q14(m2_xz, m2_su[1], 1'b0);
        r10 <= to_q14(m2_xy, m2_su[2], 1'b0);
        r11 <= to_q14(m2_yy, m2_c,     1'b0);
        r12 <= to_q14(m2_yz, m2_su[0], 1'b1);
        r20 <= to_q14(m2_xz, m2_su[1], 1'b1);
        r21 <= to_q14(m2_yz, m2_su[0], 1'b0);
        r22 <= to_q14(m2_zz, m2_c,     1'b0);
      end
    end
  end

  // ---------------------------------------------------------------- checks
  a_zero_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && axis_was_zero |->
      r00 == ENTRY_MAX && r11 == ENTRY_MAX && r22 == ENTRY_MAX &&
      r01 == 16'sd0 && r12 == 16'sd0 && r20 == 16'sd0)
    else $error("zero axis beat is not the identity");

  a_diag_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      r00 <= ENTRY_MAX && r00 >= -ENTRY_MAX &&
      r11 <= ENTRY_MAX && r11 >= -ENTRY_MAX &&
      r22 <= ENTRY_MAX && r22 >= -ENTRY_MAX)
    else $error("diagonal entry out of saturation range");

  a_pipe_advance: assert property (@(posedge clk) disable iff (rst)
    adv && m2_vld |=> out_valid)
    else $error("last multiply stage beat did not reach the output");

endmodule

`default_nettype wire

@@ tb/axis_angle_rotation_matrix_checker.sv @@
`default_nettype none

module axis_angle_rotation_matrix_checker import aarm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [15:0] angle,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] r00,
  input  logic signed [15:0] r01,
  input  logic signed [15:0] r02,
  input  logic signed [15:0] r10,
  input  logic signed [15:0] r11,
  input  logic signed [15:0] r12,
  input  logic signed [15:0] r20,
  input  logic signed [15:0] r21,
  input  logic signed [15:0] r22,
  input  logic               axis_was_zero,
  output int                 errors,
  output int                 pending
);

  typedef struct {
    logic signed [15:0] m [9];
    logic               zero;
  } rot_t;

  rot_t matrix_q[$];

  function automatic longint fshr(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return fshr(a * b + (64'sd1 <<< 27), 28);
  endfunction

  function automatic logic signed [15:0] entry(longint v);
    longint e;
    e = fshr(v + 16384, 15);
    if (e > 16384) e = 16384;
    if (e < -16384) e = -16384;
    return 16'(e);
  endfunction

  function automatic longint unsigned root(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic rot_t rodrigues(logic signed [15:0] ax, logic signed [15:0] ay,
                                     logic signed [15:0] az, logic signed [15:0] ang);
    rot_t o;
    longint a [3], u [3];
    longint unsigned n2, rr, mag, q;
    longint x, y, z, c, s, t, dx, dy;
    longint tx, ty, tz, xx, xy, xz, yy, yz, zz, sx, sy, sz;
    int k;
    bit flip;
    a[0] = ax; a[1] = ay; a[2] = az;
    o.zero = 0;
    if (ax == 0 && ay == 0 && az == 0) begin
      foreach (o.m[j]) o.m[j] = (j % 4 == 0) ? ENTRY_MAX : 16'sd0;
      o.zero = 1;
      return o;
    end
    n2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    k = 0;
    while ((n2 << 2) < (64'd1 << 32)) begin
      n2 <<= 2;
      k++;
    end
    rr = root(n2 << 28);
    for (int j = 0; j < 3; j++) begin
      mag = (a[j] < 0) ? -(a[j] <<< k) : (a[j] <<< k);
      q = ((mag << 42) + (rr >> 1)) / rr;
      u[j] = (a[j] < 0) ? -longint'(q) : longint'(q);
    end
    z = longint'(ang) * 65536;
    flip = 0;
    if (z > HALF_PI_Q29) begin
      z -= PI_Q29; flip = 1;
    end else if (z < -HALF_PI_Q29) begin
      z += PI_Q29; flip = 1;
    end
    x = GAIN_Q29;
    y = 0;
    for (int i = 0; i < CSTEPS; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q29[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q29[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    t = ONE_Q29 - c;
    tx = qmul(t, u[0]); ty = qmul(t, u[1]); tz = qmul(t, u[2]);
    xx = qmul(tx, u[0]); xy = qmul(tx, u[1]); xz = qmul(tx, u[2]);
    yy = qmul(ty, u[1]); yz = qmul(ty, u[2]); zz = qmul(tz, u[2]);
    sx = qmul(s, u[0]); sy = qmul(s, u[1]); sz = qmul(s, u[2]);
    o.m[0] = entry(xx + c);  o.m[1] = entry(xy - sz); o.m[2] = entry(xz + sy);
    o.m[3] = entry(xy + sz); o.m[4] = entry(yy + c);  o.m[5] = entry(yz - sx);
    o.m[6] = entry(xz - sy); o.m[7] = entry(yz + sx); o.m[8] = entry(zz + c);
    return o;
  endfunction

  task automatic report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  initial errors = 0;
  assign pending = matrix_q.size();

  always @(posedge clk) begin
    rot_t want;
    logic signed [15:0] got [9];
    if (!rst) begin
      if (in_valid && in_ready) matrix_q.push_back(rodrigues(axis_x, axis_y, axis_z, angle));
      if (out_valid && out_ready) begin
        got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
        if (matrix_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = matrix_q.pop_front();
          for (int j = 0; j < 9; j++)
            if (got[j] !== want.m[j])
              report($sformatf("r%0d%0d got %0d want %0d", j / 3, j % 3, got[j], want.m[j]));
          if (axis_was_zero !== want.zero)
            report($sformatf("axis_was_zero got %b want %b", axis_was_zero, want.zero));
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ tb/axis_angle_rotation_matrix_core_test.sv @@
`default_nettype none

module axis_angle_rotation_matrix_core_test;
  import aarm_pkg::*;

  localparam int LATENCY   = 68;
  localparam int MAX_CYCLE = 200000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic signed [15:0] axis_x = 0, axis_y = 0, axis_z = 0, angle = 0;
  logic in_ready, out_valid, axis_was_zero;
  logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  int errors, pending;
  int cycle = 0;
  bit calm = 0;  // no idling in the closing stretch

  always #5 clk = ~clk;

  axis_angle_rotation_matrix_core dut (.*);
  axis_angle_rotation_matrix_checker chk (.*);

  // hard stop if the pipe hangs
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stall bursts, off once calm
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (!calm && $urandom_range(3) == 0) begin
        n = $urandom_range(1, 6);
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  // one beat; valid held until accepted
  task automatic send(logic signed [15:0] x, y, z, a);
    int n;
    if (!calm && $urandom_range(3) == 0) begin
      n = $urandom_range(1, 6);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    axis_x <= x; axis_y <= y; axis_z <= z; angle <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick();
    case ($urandom_range(5))
      0: return 16'($urandom_range(0, 3)) - 16'sd1;  // tiny: -1..2
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      2: return 16'($signed($urandom_range(0, 255)) - 128);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [15:0] ext [4] = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd1};
    repeat (10) @(posedge clk);
    rst <= 0;

    // directed: zero axis, unit axes, extreme axes, angles around +-pi/2 and ends
    send(0, 0, 0, 16'sh1234);
    send(0, 0, 0, 16'sh8000);
    send(1, 0, 0, 16'sd12868);
    send(0, -1, 0, 16'sd12867);
    send(0, 0, 1, 16'sd12869);
    send(1, 1, 1, -16'sd12868);
    send(1, 1, 1, -16'sd12869);
    send(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send(16'sh8000, 0, 0, 0);
    send(0, 16'sh7fff, 16'sh8000, 16'sd25736);
    send(-1, -1, -1, -16'sd25736);
    send(3, -4, 12, 16'sd8192);
    foreach (ext[i]) send(ext[i], ext[3 - i], ext[(i + 1) % 4], ext[(i + 2) % 4]);

    // hold off until the pipe has drained
    in_valid <= 0;
    @(posedge clk iff pending == 0);

    for (int i = 0; i < 550; i++) begin
      if (i == 460) calm = 1;
      if ($urandom_range(40) == 0) send(0, 0, 0, 16'($urandom));
      else send(pick(), pick(), pick(), 16'($urandom));
    end
    in_valid <= 0;

    @(posedge clk iff pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/aarm_pkg.sv
rtl/axis_angle_rotation_matrix_core.sv
tb/axis_angle_rotation_matrix_checker.sv
tb/axis_angle_rotation_matrix_core_test.sv
